@@ rtl/ippl_pkg.sv @@
// Shared types, constants and helpers for the IR pulse pattern learner/matcher.
// No dependencies; used by every module under rtl/.
package ippl_pkg;

    localparam int MAX_PULSES    = 32;
    localparam int DUR_W         = 16;
    localparam int TOL_W         = 16;
    localparam int CNT_W         = 6;
    localparam int STORE_DEPTH   = 2 * MAX_PULSES;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] LEARN_CNT_A = CNT_W'(8);
    localparam logic [CNT_W-1:0] LEARN_CNT_B = CNT_W'(16);
    localparam logic [CNT_W-1:0] LEARN_CNT_C = CNT_W'(32);
    localparam logic [CNT_W-1:0] MAX_IDX     = CNT_W'(MAX_PULSES);

    localparam logic [TOL_W-1:0] START_TOL_RST = TOL_W'(250);
    localparam logic [TOL_W-1:0] BIT_TOL_RST   = TOL_W'(100);

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BIT   = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TOL  = 2'd0,
        CFG_BIT_TOL    = 2'd1,
        CFG_LEARN_MODE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [TOL_W-1:0] start_tol;
        logic [TOL_W-1:0] bit_tol;
        logic             learn_mode;
    } t_cfg;

    typedef struct packed {
        logic             matched;
        logic             learned;
        logic             pattern_present;
        logic [CNT_W-1:0] frame_pulses;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DUR_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [DUR_W-1:0] abs_diff(input logic [DUR_W-1:0] a,
                                                  input logic [DUR_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic bank,
                                                     input logic [CNT_W-1:0] idx);
        store_addr = bank ? (ADDR_W'(MAX_PULSES) + ADDR_W'(idx)) : ADDR_W'(idx);
    endfunction

endpackage

@@ rtl/ippl_store.sv @@
// Pulse store: two banks of bit durations, one write and one read port.
// Read data registered. Uses ippl_pkg.
module ippl_store (
    input  logic                         i_clk,
    input  ippl_pkg::t_mem_req           i_req,
    output logic [ippl_pkg::DUR_W-1:0]   o_rdata
);

    logic [ippl_pkg::DUR_W-1:0] r_mem [ippl_pkg::STORE_DEPTH];
    logic [ippl_pkg::DUR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ippl_frame.sv @@
// Frame tracker: counts pulses, drives the pulse store, compares bits in the
// cycle after the store read, evaluates and learns at frame end. Uses ippl_pkg.
module ippl_frame (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_acc,
    input  logic [1:0]                  i_kind,
    input  logic [ippl_pkg::DUR_W-1:0]  i_duration,
    input  ippl_pkg::t_cfg              i_cfg,
    output ippl_pkg::t_mem_req          o_req,
    input  logic [ippl_pkg::DUR_W-1:0]  i_rdata,
    output logic                        o_res_valid,
    output ippl_pkg::t_result           o_res
);

    logic                              r_bank, n_bank;
    logic [ippl_pkg::CNT_W-1:0]        r_pat_count, n_pat_count;
    logic [ippl_pkg::DUR_W-1:0]        r_pat_start, n_pat_start;
    logic [ippl_pkg::DUR_W-1:0]        r_frame_start, n_frame_start;
    logic [ippl_pkg::CNT_W-1:0]        r_frame_count, n_frame_count;
    logic                              r_running_ok, n_running_ok;
    logic                              r_overflow, n_overflow;
    logic                              r_have, n_have;
    logic                              r_pend, n_pend;
    logic [ippl_pkg::DUR_W-1:0]        r_pend_dur;
    logic [ippl_pkg::TOL_W-1:0]        r_pend_tol;

    logic fail;
    logic ok_eff;
    logic len_ok;

    // compare for the bit pulse taken last cycle, against the registered read;
    // tolerance is the one in force when that pulse was taken
    assign fail   = r_pend &&
                    (ippl_pkg::abs_diff(r_pend_dur, i_rdata) > r_pend_tol);
    assign ok_eff = r_running_ok && !fail;
    assign len_ok = (r_frame_count == ippl_pkg::LEARN_CNT_A) ||
                    (r_frame_count == ippl_pkg::LEARN_CNT_B) ||
                    (r_frame_count == ippl_pkg::LEARN_CNT_C);

    always_comb begin
        n_bank        = r_bank;
        n_pat_count   = r_pat_count;
        n_pat_start   = r_pat_start;
        n_frame_start = r_frame_start;
        n_frame_count = r_frame_count;
        n_running_ok  = ok_eff;
        n_overflow    = r_overflow;
        n_have        = r_have;
        n_pend        = 1'b0;
        o_req.we      = 1'b0;
        o_req.waddr   = ippl_pkg::store_addr(~r_bank, r_frame_count);
        o_req.wdata   = i_duration;
        o_req.re      = 1'b0;
        o_req.raddr   = ippl_pkg::store_addr(r_bank, r_frame_count);
        o_res_valid   = 1'b0;
        o_res.matched         = 1'b0;
        o_res.learned         = 1'b0;
        o_res.pattern_present = r_have;
        o_res.frame_pulses    = r_frame_count;

        if (i_acc) begin
            unique case (i_kind)
                ippl_pkg::KIND_START: begin
                    n_frame_start = i_duration;
                    n_frame_count = '0;
                    n_running_ok  = 1'b1;
                    n_overflow    = 1'b0;
                end
                ippl_pkg::KIND_BIT: begin
                    if (r_frame_count < ippl_pkg::MAX_IDX) begin
                        o_req.we = 1'b1;
                        if (r_have && (r_frame_count < r_pat_count)) begin
                            o_req.re = 1'b1;
                            n_pend   = 1'b1;
                        end
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (r_frame_count != ippl_pkg::COUNT_MAX) begin
                        n_frame_count = r_frame_count + 1'b1;
                    end
                end
                ippl_pkg::KIND_END: begin
                    o_res_valid = 1'b1;
                    if (i_cfg.learn_mode) begin
                        if (!r_overflow && len_ok) begin
                            n_bank        = ~r_bank;
                            n_pat_count   = r_frame_count;
                            n_pat_start   = r_frame_start;
                            n_have        = 1'b1;
                            o_res.learned = 1'b1;
                        end
                    end else begin
                        o_res.matched = r_have && !r_overflow && ok_eff &&
                            (r_frame_count == r_pat_count) &&
                            (ippl_pkg::abs_diff(r_frame_start, r_pat_start)
                             <= i_cfg.start_tol);
                    end
                    o_res.pattern_present = n_have;
                    n_frame_start = '0;
                    n_frame_count = '0;
                    n_running_ok  = 1'b1;
                    n_overflow    = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank        <= 1'b0;
            r_pat_count   <= '0;
            r_pat_start   <= '0;
            r_frame_start <= '0;
            r_frame_count <= '0;
            r_running_ok  <= 1'b1;
            r_overflow    <= 1'b0;
            r_have        <= 1'b0;
            r_pend        <= 1'b0;
        end else begin
            r_bank        <= n_bank;
            r_pat_count   <= n_pat_count;
            r_pat_start   <= n_pat_start;
            r_frame_start <= n_frame_start;
            r_frame_count <= n_frame_count;
            r_running_ok  <= n_running_ok;
            r_overflow    <= n_overflow;
            r_have        <= n_have;
            r_pend        <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_pend) begin
            r_pend_dur <= i_duration;
            r_pend_tol <= i_cfg.bit_tol;
        end
    end

endmodule

@@ rtl/ir_pulse_pattern_learn_match.sv @@
// Top level of the learning IR pulse timing matcher.
// Depends on ippl_pkg, ippl_store and ippl_frame.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready, fields i_kind, i_duration) carries
//    one measured pulse per transfer: start pulse, bit pulse or frame end.
//    Kind 3 is swallowed without effect.
//  - Output channel (o_out_valid / i_out_ready) delivers one result per frame
//    end: matched, learned, pattern_present and the saturated pulse count.
//  - Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) is
//    always ready; index 0 start tolerance, 1 bit tolerance, 2 learn mode,
//    index 3 is ignored. Write it only while no frame end is in flight.
//  - Throughput: one pulse per cycle unless the output stalls. Each bit pulse
//    writes the inactive store bank and reads the active one in the same
//    cycle; the tolerance compare runs on the registered read data in the following
//    cycle, folded straight into a frame end taken then; the compare adds no stall.
//  - Latency: a frame end result appears in the output register on the cycle
//    after its transfer.
//  - Stall: a held result blocks only when the receiver stalls; the input is
//    then not ready until the result is taken (ready tracks i_out_ready).
//  - Reset (synchronous, active low) clears pattern, frame state and bank
//    selection and loads the default tolerances; no store clearing pass is
//    needed since entries are only read once written.
module ir_pulse_pattern_learn_match (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_kind,
    input  logic [ippl_pkg::DUR_W-1:0]        i_duration,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_matched,
    output logic                              o_learned,
    output logic                              o_pattern_present,
    output logic [ippl_pkg::CNT_W-1:0]        o_frame_pulses,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ippl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ippl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    ippl_pkg::t_cfg      r_cfg, n_cfg;
    ippl_pkg::t_mem_req  mem_req;
    ippl_pkg::t_result   res;
    ippl_pkg::t_result   r_out;
    logic                r_out_valid, n_out_valid;
    logic                res_valid;
    logic                in_acc;
    logic [ippl_pkg::DUR_W-1:0] rdata;

    // output register frees up in the same cycle it is taken
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // config register file
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ippl_pkg::CFG_START_TOL:  n_cfg.start_tol  = i_cfg_data;
                ippl_pkg::CFG_BIT_TOL:    n_cfg.bit_tol    = i_cfg_data;
                ippl_pkg::CFG_LEARN_MODE: n_cfg.learn_mode = i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_tol  <= ippl_pkg::START_TOL_RST;
            r_cfg.bit_tol    <= ippl_pkg::BIT_TOL_RST;
            r_cfg.learn_mode <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    ippl_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (in_acc),
        .i_kind      (i_kind),
        .i_duration  (i_duration),
        .i_cfg       (r_cfg),
        .o_req       (mem_req),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ippl_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_matched         = r_out.matched;
    assign o_learned         = r_out.learned;
    assign o_pattern_present = r_out.pattern_present;
    assign o_frame_pulses    = r_out.frame_pulses;

endmodule
